FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, disabled while reset is low.
`define ASSERT_CLKRST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Shorthand for the usual clock and reset names of this project.
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_CLKRST(label, clk_i, rst_ni, prop, msg)

`endif

FILE: hw/rtl/cstp_pkg.sv
// ----------------------------------------------------------------------------
// cstp_pkg
// Shared constants and codes of the call stack time profiler.
// ----------------------------------------------------------------------------
package cstp_pkg;

  // Default configuration.
  localparam int unsigned StackDepthDef = 64;
  localparam int unsigned IdBitsDef     = 16;
  localparam int unsigned TimeBitsDef   = 48;

  // The overflow counter has a fixed width and saturates.
  localparam int unsigned         OvfBits = 16;
  localparam logic [OvfBits-1:0]  OvfMax  = '1;

  // Event kinds carried on the input tuser.
  typedef enum logic [2:0] {
    FUNC_CALL    = 3'd0,
    FUNC_TAIL    = 3'd1,
    FUNC_RETURN  = 3'd2,
    FUNC_SUSPEND = 3'd3,
    FUNC_RESUME  = 3'd4
  } func_e;

endpackage

FILE: hw/rtl/call_stack_time_profiler_top.sv
// ----------------------------------------------------------------------------
// call_stack_time_profiler_top
// Shadow call stack that times function calls with suspended time excluded.
// Call, tail call, suspend and resume are accepted in IDLE and applied in
// EXEC, which updates the frame memory or the time registers. A return is
// accepted in IDLE and reads the top frame in EXEC; POP then emits one result
// per popped frame, the first after the registered read of the frame memory.
// Output backpressure stalls POP. Reset clears the stack pointer,
// the time registers and the overflow counter at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module call_stack_time_profiler_top #(
  parameter int unsigned STACK_DEPTH = cstp_pkg::StackDepthDef,
  parameter int unsigned ID_BITS     = cstp_pkg::IdBitsDef,
  parameter int unsigned TIME_BITS   = cstp_pkg::TimeBitsDef,
  localparam int unsigned InDataW    = ((ID_BITS + TIME_BITS + 7) / 8) * 8,
  localparam int unsigned OutDataW   = ((2 * ID_BITS + TIME_BITS + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Event input.
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // func_id, now
  input  logic [2:0]          s_axis_tuser_i,   // func
  // Result output.
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // callee_id, caller_id, elapsed
  output logic                m_axis_tuser_o,   // caller_valid
  output logic                m_axis_tlast_o
);

  // Address of one frame, and a depth counter that can hold the full depth.
  localparam int unsigned AddrW  = $clog2(STACK_DEPTH);
  localparam int unsigned DepthW = $clog2(STACK_DEPTH + 1);
  // A frame word holds {tail mark, function id, start stamp}.
  localparam int unsigned FrameW = 1 + ID_BITS + TIME_BITS;

  localparam logic [DepthW-1:0] DepthFull = DepthW'(STACK_DEPTH);

  // IDLE takes a transaction, EXEC applies it, POP emits popped frames.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP
  } state_e;

  state_e                       state_q, state_d;
  logic [DepthW-1:0]            depth_q, depth_d;
  logic [cstp_pkg::OvfBits-1:0] ovf_q, ovf_d;
  logic [TIME_BITS-1:0]         susp_q, susp_d;
  logic [TIME_BITS-1:0]         leave_q, leave_d;
  logic                         pend_q, pend_d;
  logic                         m_valid_q, m_valid_d;

  // Latched event. The stamp is now minus the suspended total for calls and
  // returns, now minus the leave time for a resume, and now for a suspend,
  // so that each later step needs only one wide add.
  cstp_pkg::func_e              func_q;
  logic [ID_BITS-1:0]           id_q;
  logic [TIME_BITS-1:0]         stamp_q;
  logic [TIME_BITS-1:0]         stamp_sub;
  logic                         in_accept;

  // Result register.
  logic [ID_BITS-1:0]           callee_q;
  logic [ID_BITS-1:0]           caller_q;
  logic                         cvalid_q;
  logic [TIME_BITS-1:0]         elapsed_q;
  logic                         last_q;
  logic                         out_load;

  // Frame memory with one write port and two registered read ports: the top
  // frame and the id of the frame just below it.
  logic [FrameW-1:0]            frame_mem [STACK_DEPTH];
  logic                         mem_we;
  logic                         rd_en;
  logic [DepthW-1:0]            rd_depth;
  logic [DepthW-1:0]            rd_top;
  logic [DepthW-1:0]            rd_below;
  logic [FrameW-1:0]            rd_top_q;
  logic [ID_BITS-1:0]           rd_below_q;
  logic                         pop_more;
  logic                         pop_cvalid;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  // Pick what is taken off the incoming timestamp.
  always_comb begin
    case (cstp_pkg::func_e'(s_axis_tuser_i))
      cstp_pkg::FUNC_SUSPEND: stamp_sub = '0;
      cstp_pkg::FUNC_RESUME:  stamp_sub = leave_q;
      default:                stamp_sub = susp_q;
    endcase
  end

  // The first read of a return addresses the current top; a chained read
  // addresses the frame that becomes the top once this pop is taken.
  assign rd_depth = (state_q == S_POP) ? (depth_q - DepthW'(1)) : depth_q;
  assign rd_top   = rd_depth - DepthW'(1);
  assign rd_below = rd_depth - DepthW'(2);

  // The popped frame leaves a caller behind when more than one frame was
  // stacked, and a tail-call frame keeps the chain going in that case.
  assign pop_cvalid = (depth_q > DepthW'(1));
  assign pop_more   = rd_top_q[FrameW-1] && pop_cvalid;

  always_comb begin
    state_d   = state_q;
    depth_d   = depth_q;
    ovf_d     = ovf_q;
    susp_d    = susp_q;
    leave_d   = leave_q;
    pend_d    = pend_q;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    out_load  = 1'b0;
    m_valid_d = m_valid_q;
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (func_q)
          cstp_pkg::FUNC_CALL, cstp_pkg::FUNC_TAIL: begin
            if (depth_q == DepthFull) begin
              // Pushes past the top are only counted.
              if (ovf_q != cstp_pkg::OvfMax) begin
                ovf_d = ovf_q + cstp_pkg::OvfBits'(1);
              end
            end else begin
              mem_we  = 1'b1;
              depth_d = depth_q + DepthW'(1);
            end
          end
          cstp_pkg::FUNC_RETURN: begin
            // Returns first drain the overflow count without a result.
            if (ovf_q != '0) begin
              ovf_d = ovf_q - cstp_pkg::OvfBits'(1);
            end else if (depth_q != '0) begin
              rd_en   = 1'b1;
              state_d = S_POP;
            end
          end
          cstp_pkg::FUNC_SUSPEND: begin
            leave_d = stamp_q;
            pend_d  = 1'b1;
          end
          cstp_pkg::FUNC_RESUME: begin
            if (pend_q) begin
              susp_d  = susp_q + stamp_q;
              pend_d  = 1'b0;
              leave_d = '0;
            end
          end
          default: begin
          end
        endcase
      end
      S_POP: begin
        // Wait here while the result register still holds an untaken result.
        if (!m_valid_q || m_axis_tready_i) begin
          out_load  = 1'b1;
          m_valid_d = 1'b1;
          depth_d   = depth_q - DepthW'(1);
          if (pop_more) begin
            rd_en = 1'b1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and the output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      depth_q   <= '0;
      ovf_q     <= '0;
      susp_q    <= '0;
      leave_q   <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      depth_q   <= depth_d;
      ovf_q     <= ovf_d;
      susp_q    <= susp_d;
      leave_q   <= leave_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Latched event and result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q  <= cstp_pkg::func_e'(s_axis_tuser_i);
      id_q    <= s_axis_tdata_i[ID_BITS-1:0];
      stamp_q <= s_axis_tdata_i[ID_BITS +: TIME_BITS] - stamp_sub;
    end
    if (out_load) begin
      callee_q  <= rd_top_q[TIME_BITS +: ID_BITS];
      caller_q  <= pop_cvalid ? rd_below_q : '0;
      cvalid_q  <= pop_cvalid;
      elapsed_q <= stamp_q - rd_top_q[TIME_BITS-1:0];
      last_q    <= !pop_more;
    end
  end

  // Frame memory: the write stores the pushed frame at the current depth.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[depth_q[AddrW-1:0]] <= {(func_q == cstp_pkg::FUNC_TAIL), id_q, stamp_q};
    end
    if (rd_en) begin
      rd_top_q   <= frame_mem[rd_top[AddrW-1:0]];
      rd_below_q <= frame_mem[rd_below[AddrW-1:0]][TIME_BITS +: ID_BITS];
    end
  end

  // Output packing, first field in the lowest bits.
  always_comb begin
    m_axis_tdata_o = '0;
    m_axis_tdata_o[ID_BITS-1:0]               = callee_q;
    m_axis_tdata_o[ID_BITS +: ID_BITS]        = caller_q;
    m_axis_tdata_o[2 * ID_BITS +: TIME_BITS]  = elapsed_q;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = cvalid_q;
  assign m_axis_tlast_o  = last_q;

  // The stack pointer never runs past the memory.
  `ASSERT_STD(a_depth_bound, depth_q <= DepthFull, "stack depth beyond memory size")
  // Overflowed pushes can only be pending while the stack is full.
  `ASSERT_STD(a_ovf_full, (ovf_q != '0) |-> (depth_q == DepthFull), "overflow with free frames")
  // A new result only ever comes out of the pop state.
  `ASSERT_STD(a_result_from_pop, $rose(m_valid_q) |-> $past(state_q == S_POP), "result outside pop")

endmodule
